### design/ssum_pkg.sv
// Shared types, constants and character codes of the signed number text summer.
`timescale 1ns / 1ps

package ssum_pkg;

  // Arithmetic width of numbers and of the running sum
  localparam int VALUE_WIDTH = 64;
  // Width of the total field on the result stream
  localparam int TOTAL_WIDTH = 64;
  localparam int STATUS_WIDTH = 2;
  localparam int IN_DATA_WIDTH = 8;
  localparam int OUT_FIELDS_WIDTH = STATUS_WIDTH + TOTAL_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH = OUT_DATA_WIDTH - OUT_FIELDS_WIDTH;

  // Largest magnitude a negative number may carry, 2^(VALUE_WIDTH-1)
  localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
  // Largest magnitude a positive number may carry
  localparam logic [VALUE_WIDTH-1:0] MAG_MAX = MAG_LIMIT - VALUE_WIDTH'(1);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  // Digit value that marks "not a digit"
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_VT,
    PH_AFTER_SIGN,
    PH_LEAD_ZERO,
    PH_HEX_PREFIX,
    PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK,
    ST_PARSE_ERROR,
    ST_OVERFLOW
  } status_e;

  // Complete parser state carried from one byte to the next
  typedef struct packed {
    phase_e                 phase;
    base_e                  base;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   mag_ovf;
    logic [VALUE_WIDTH-1:0] total;
    status_e                error;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_START,
    base:      BASE_DEC,
    negative:  1'b0,
    magnitude: '0,
    mag_ovf:   1'b0,
    total:     '0,
    error:     ST_OK
  };

endpackage

### design/ssum_step.sv
// Per-byte parse and accumulate step of the signed number text summer.
`timescale 1ns / 1ps

module ssum_step (
  input  ssum_pkg::parse_state_t           st_i,
  input  logic [7:0]                       byte_i,
  input  logic                             last_i,
  output ssum_pkg::parse_state_t           st_o,
  output ssum_pkg::status_e                status_o,
  output logic [ssum_pkg::TOTAL_WIDTH-1:0] total_o
);

  localparam int W = ssum_pkg::VALUE_WIDTH;

  ssum_pkg::parse_state_t st_feed;
  ssum_pkg::parse_state_t st_end;

  function automatic logic is_dec(logic [7:0] c);
    return (c >= ssum_pkg::CH_ZERO) && (c <= ssum_pkg::CH_NINE);
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    d = ssum_pkg::DIGIT_NONE;
    if (is_dec(c)) begin
      d = 5'(c - ssum_pkg::CH_ZERO);
    end else if ((c >= ssum_pkg::CH_LC_A) && (c <= ssum_pkg::CH_LC_F)) begin
      d = 5'(c - ssum_pkg::CH_LC_A + 8'd10);
    end else if ((c >= ssum_pkg::CH_UC_A) && (c <= ssum_pkg::CH_UC_F)) begin
      d = 5'(c - ssum_pkg::CH_UC_A + 8'd10);
    end
    return d;
  endfunction

  function automatic logic fits_base(ssum_pkg::base_e b, logic [4:0] d);
    logic ok;
    case (b)
      ssum_pkg::BASE_OCT: ok = (d < 5'd8);
      ssum_pkg::BASE_HEX: ok = (d < 5'd16);
      default:            ok = (d < 5'd10);
    endcase
    return ok;
  endfunction

  function automatic ssum_pkg::parse_state_t clear_number(ssum_pkg::parse_state_t s);
    ssum_pkg::parse_state_t r;
    r = s;
    r.phase     = ssum_pkg::PH_START;
    r.base      = ssum_pkg::BASE_DEC;
    r.negative  = 1'b0;
    r.magnitude = '0;
    r.mag_ovf   = 1'b0;
    return r;
  endfunction

  // Range check of the number, then an add with signed overflow check
  function automatic ssum_pkg::parse_state_t finish_number(ssum_pkg::parse_state_t s);
    ssum_pkg::parse_state_t r;
    logic                   too_big;
    logic [W-1:0]           v;
    logic [W:0]             sum;
    r = s;
    too_big = s.mag_ovf ||
              (s.negative ? (s.magnitude > ssum_pkg::MAG_LIMIT)
                          : (s.magnitude > ssum_pkg::MAG_MAX));
    v   = s.negative ? (~s.magnitude + W'(1)) : s.magnitude;
    sum = {s.total[W-1], s.total} + {v[W-1], v};
    if (too_big || (sum[W] != sum[W-1])) begin
      r.error = ssum_pkg::ST_OVERFLOW;
    end else begin
      r       = clear_number(s);
      r.total = sum[W-1:0];
    end
    return r;
  endfunction

  function automatic ssum_pkg::parse_state_t begin_digit(ssum_pkg::parse_state_t s,
                                                         logic [7:0] c);
    ssum_pkg::parse_state_t r;
    r = s;
    if (c == ssum_pkg::CH_ZERO) begin
      r.magnitude = '0;
      r.phase     = ssum_pkg::PH_LEAD_ZERO;
    end else begin
      r.base      = ssum_pkg::BASE_DEC;
      r.magnitude = W'(c[3:0]);
      r.phase     = ssum_pkg::PH_DIGITS;
    end
    return r;
  endfunction

  function automatic ssum_pkg::parse_state_t start_char(ssum_pkg::parse_state_t s,
                                                        logic [7:0] c);
    ssum_pkg::parse_state_t r;
    r = s;
    if (c == ssum_pkg::CH_VT) begin
      r.phase = ssum_pkg::PH_AFTER_VT;
    end else if ((c == ssum_pkg::CH_PLUS) || (c == ssum_pkg::CH_MINUS)) begin
      r.negative = (c == ssum_pkg::CH_MINUS);
      r.phase    = ssum_pkg::PH_AFTER_SIGN;
    end else if (is_dec(c)) begin
      r = begin_digit(s, c);
    end else begin
      r.error = ssum_pkg::ST_PARSE_ERROR;
    end
    return r;
  endfunction

  // magnitude * radix + digit, by shifts and adds; overflow once above MAG_LIMIT
  function automatic ssum_pkg::parse_state_t accumulate(ssum_pkg::parse_state_t s,
                                                        logic [4:0] d);
    ssum_pkg::parse_state_t r;
    logic [W+3:0]           ext;
    logic [W+3:0]           prod;
    r    = s;
    ext  = {4'b0, s.magnitude};
    case (s.base)
      ssum_pkg::BASE_OCT: prod = ext << 3;
      ssum_pkg::BASE_HEX: prod = ext << 4;
      default:            prod = (ext << 3) + (ext << 1);
    endcase
    prod = prod + (W + 4)'(d);
    if (!s.mag_ovf) begin
      if (prod > {4'b0, ssum_pkg::MAG_LIMIT}) begin
        r.mag_ovf = 1'b1;
      end else begin
        r.magnitude = prod[W-1:0];
      end
    end
    return r;
  endfunction

  function automatic ssum_pkg::parse_state_t terminate(ssum_pkg::parse_state_t s,
                                                       logic [7:0] c);
    ssum_pkg::parse_state_t r;
    r = finish_number(s);
    if (r.error == ssum_pkg::ST_OK) begin
      r = start_char(r, c);
    end
    return r;
  endfunction

  // Next state after one byte
  always_comb begin
    logic [4:0] d;
    logic       dropped;
    d       = digit_of(byte_i);
    dropped = (byte_i == ssum_pkg::CH_NUL) || (byte_i == ssum_pkg::CH_SPACE) ||
              (byte_i == ssum_pkg::CH_TAB) || (byte_i == ssum_pkg::CH_LF) ||
              (byte_i == ssum_pkg::CH_CR)  || (byte_i == ssum_pkg::CH_BS) ||
              (byte_i == ssum_pkg::CH_FF)  || (byte_i == ssum_pkg::CH_BEL);
    st_feed = st_i;
    if ((st_i.error == ssum_pkg::ST_OK) && !dropped) begin
      unique case (st_i.phase)
        ssum_pkg::PH_AFTER_SIGN: begin
          if (is_dec(byte_i)) begin
            st_feed = begin_digit(st_i, byte_i);
          end else begin
            st_feed.error = ssum_pkg::ST_PARSE_ERROR;
          end
        end
        ssum_pkg::PH_LEAD_ZERO: begin
          if ((byte_i == ssum_pkg::CH_LC_X) || (byte_i == ssum_pkg::CH_UC_X)) begin
            st_feed.phase = ssum_pkg::PH_HEX_PREFIX;
          end else if ((byte_i >= ssum_pkg::CH_ZERO) && (byte_i <= ssum_pkg::CH_SEVEN)) begin
            st_feed.base      = ssum_pkg::BASE_OCT;
            st_feed.magnitude = W'(d);
            st_feed.phase     = ssum_pkg::PH_DIGITS;
          end else begin
            st_feed = terminate(st_i, byte_i);
          end
        end
        ssum_pkg::PH_HEX_PREFIX: begin
          if (d < ssum_pkg::DIGIT_NONE) begin
            st_feed.base      = ssum_pkg::BASE_HEX;
            st_feed.magnitude = W'(d);
            st_feed.phase     = ssum_pkg::PH_DIGITS;
          end else begin
            st_feed.error = ssum_pkg::ST_PARSE_ERROR;
          end
        end
        ssum_pkg::PH_DIGITS: begin
          if (fits_base(st_i.base, d)) begin
            st_feed = accumulate(st_i, d);
          end else begin
            st_feed = terminate(st_i, byte_i);
          end
        end
        default: begin
          st_feed = start_char(st_i, byte_i);
        end
      endcase
    end
  end

  // Close off the expression: pending number or dangling prefix
  always_comb begin
    st_end = st_feed;
    if (st_feed.error == ssum_pkg::ST_OK) begin
      unique case (st_feed.phase) inside
        ssum_pkg::PH_AFTER_VT, ssum_pkg::PH_AFTER_SIGN, ssum_pkg::PH_HEX_PREFIX: begin
          st_end.error = ssum_pkg::ST_PARSE_ERROR;
        end
        ssum_pkg::PH_LEAD_ZERO, ssum_pkg::PH_DIGITS: begin
          st_end = finish_number(st_feed);
        end
        default: begin
          st_end = st_feed;
        end
      endcase
    end
  end

  // Outputs: result fields and the state handed back
  always_comb begin
    status_o = st_end.error;
    total_o  = (st_end.error != ssum_pkg::ST_OK) ? '0
             : ssum_pkg::TOTAL_WIDTH'($signed(st_end.total));
    st_o     = last_i ? ssum_pkg::STATE_RESET : st_feed;
  end

endmodule

### design/signed_number_text_summer.sv
// Top level of the signed number text summer: stream ports, input and result registers.
`timescale 1ns / 1ps

// Takes one text byte per transaction and adds up the signed integers written
// in it (optional sign, 0x hex, leading-0 octal, else decimal); blanks and
// the control bytes NUL, BEL, BS, LF, FF and CR are skipped. The byte marked
// with tlast closes the expression and produces one result transaction
// carrying the status and the 64-bit total; the parser then starts afresh.
// One byte is accepted every cycle; the result is registered. The cycle
// time is set by the per-byte step logic (radix multiply-add by shifts and the
// two chained 65-bit sum adders). Input only stalls while a finished result
// is held back by the downstream side and another last byte is waiting.
module signed_number_text_summer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // text_byte [7:0]
  input  logic [ssum_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
  // is_last
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status [1:0], total [65:2], zero padding [71:66]
  output logic [ssum_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  logic                                 in_valid_q, in_valid_d;
  logic [ssum_pkg::IN_DATA_WIDTH-1:0]   in_byte_q;
  logic                                 in_last_q;
  ssum_pkg::parse_state_t               st_q, st_d;
  logic                                 out_valid_q, out_valid_d;
  ssum_pkg::status_e                    out_status_q, step_status;
  logic [ssum_pkg::TOTAL_WIDTH-1:0]     out_total_q, step_total;
  logic                                 out_free;
  logic                                 fire;
  logic                                 in_accept;

  // Handshake: the step fires unless a last byte finds the result slot taken
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ssum_step u_step (
    .st_i     (st_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .st_o     (st_d),
    .status_o (step_status),
    .total_o  (step_total)
  );

  // Input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= ssum_pkg::STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (fire && in_last_q) begin
      out_status_q <= step_status;
      out_total_q  <= step_total;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{ssum_pkg::OUT_PAD_WIDTH{1'b0}}, out_total_q, out_status_q};

endmodule

### design/ssum_checker.sv
// Port-level checker of the signed number text summer, bound to the top level.
`timescale 1ns / 1ps

module ssum_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [ssum_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
  input logic                                s_axis_tlast,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ssum_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  localparam int SW = ssum_pkg::STATUS_WIDTH;
  localparam int FW = ssum_pkg::OUT_FIELDS_WIDTH;

  // A stalled result transaction holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[SW-1:0] == ssum_pkg::ST_OK) ||
                      (m_axis_tdata[SW-1:0] == ssum_pkg::ST_PARSE_ERROR) ||
                      (m_axis_tdata[SW-1:0] == ssum_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // An error result carries a zero total
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[SW-1:0] != ssum_pkg::ST_OK) |->
      (m_axis_tdata[FW-1:SW] == '0))
    else $error("nonzero total with error status");

  // No result without a preceding input transaction
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready, 2) || $past(s_axis_tvalid, 2) ||
                             !$past(s_axis_tready, 1))
    else $error("result appeared with no input pending");

endmodule

bind signed_number_text_summer ssum_checker u_ssum_checker (.*);
